// ===== rtl/tbppu_pkg.sv =====
// shared types, codes and address helpers of the tile background video unit
// no dependencies
package tbppu_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [2:0] REG_CTRL   = 3'd0;
   localparam logic [2:0] REG_MASK   = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam int PAT_DEPTH = 8192;
   localparam int NT_DEPTH  = 2048;
   localparam int PAT_AW    = $clog2(PAT_DEPTH);
   localparam int NT_AW     = $clog2(NT_DEPTH);
   localparam logic [7:0] MEM_FILL = 8'h80;

   localparam logic [8:0] LAST_DOT   = 9'd340;
   localparam logic [8:0] PRE_ROW    = 9'd261;
   localparam logic [8:0] VBL_ROW    = 9'd241;
   localparam logic [8:0] VIS_ROWS   = 9'd240;

   typedef struct packed {
      logic              rd_en;
      logic [PAT_AW-1:0] pat_raddr;
      logic [NT_AW-1:0]  nt_raddr;
      logic              pat_we;
      logic              nt_we;
      logic [PAT_AW-1:0] pat_waddr;
      logic [NT_AW-1:0]  nt_waddr;
      logic [7:0]        wdata;
   } vram_req_type;

   // nametable bank select by mirroring
   function automatic logic [NT_AW-1:0] nt_index(input logic [11:0] a, input logic mirror);
      logic bank;
      bank = mirror ? a[11] : a[10];
      return {bank, a[9:0]};
   endfunction

   // backdrop entries of the sprite half alias the background half
   function automatic logic [4:0] pal_index(input logic [4:0] a);
      logic [4:0] r;
      r = a;
      if (a[4] && (a[1:0] == 2'b00)) r = {1'b0, a[3:0]};
      return r;
   endfunction

   function automatic logic [8:0] eff_dot(input logic [8:0] row, input logic [8:0] dot);
      return ((row == 9'd0) && (dot == 9'd0)) ? 9'd1 : dot;
   endfunction

   // vram address read by a transaction, from the state it starts with
   function automatic logic [13:0] fetch_addr(
      input logic [1:0]  cmd,
      input logic [8:0]  row,
      input logic [8:0]  dot,
      input logic [15:0] v,
      input logic        pt_sel,
      input logic [7:0]  nti
   );
      logic [8:0]  d;
      logic [8:0]  dm1;
      logic [13:0] a;
      d   = eff_dot(row, dot);
      dm1 = d - 9'd1;
      a   = v[13:0];
      if (cmd == CMD_TICK) begin
         if ((d == 9'd338) || (d == 9'd340) || (dm1[2:0] == 3'd0)) begin
            a = {2'b10, v[11:0]};
         end else if (dm1[2:0] == 3'd2) begin
            a = {2'b10, v[11:10], 4'b1111, v[9:7], v[4:2]};
         end else if (dm1[2:0] == 3'd4) begin
            a = {1'b0, pt_sel, nti, 1'b0, v[14:12]};
         end else begin
            a = {1'b0, pt_sel, nti, 1'b1, v[14:12]};
         end
      end
      return a;
   endfunction

endpackage

// ===== rtl/tbppu_vram.sv =====
// pattern and nametable memories with registered read, write forwarding and fill sweep
// depends on tbppu_pkg
module tbppu_vram (
   input  logic                       clock,
   input  logic                       reset,
   input  tbppu_pkg::vram_req_type    req,
   output logic [7:0]                 pat_rdata,
   output logic [7:0]                 nt_rdata,
   output logic                       fill_done
);

   logic [7:0] pat_mem [tbppu_pkg::PAT_DEPTH];
   logic [7:0] nt_mem  [tbppu_pkg::NT_DEPTH];

   logic [tbppu_pkg::PAT_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic                         clr_done_ff, clr_done_in;
   logic [7:0]                   pat_q_ff, nt_q_ff, fwd_data_ff;
   logic                         pat_fwd_ff, nt_fwd_ff;

   logic                         pat_we, nt_we;
   logic [tbppu_pkg::PAT_AW-1:0] pat_waddr;
   logic [tbppu_pkg::NT_AW-1:0]  nt_waddr;
   logic [7:0]                   wdata;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == tbppu_pkg::PAT_AW'(tbppu_pkg::PAT_DEPTH - 1)) clr_done_in = 1'b1;
      end
      if (clr_done_ff) begin
         pat_we    = req.pat_we;
         nt_we     = req.nt_we;
         pat_waddr = req.pat_waddr;
         nt_waddr  = req.nt_waddr;
         wdata     = req.wdata;
      end else begin
         pat_we    = 1'b1;
         nt_we     = 1'b1;
         pat_waddr = clr_cnt_ff;
         nt_waddr  = clr_cnt_ff[tbppu_pkg::NT_AW-1:0];
         wdata     = tbppu_pkg::MEM_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_done_ff <= clr_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pat_waddr] <= wdata;
      if (req.rd_en) pat_q_ff <= pat_mem[req.pat_raddr];
   end

   always_ff @(posedge clock) begin
      if (nt_we) nt_mem[nt_waddr] <= wdata;
      if (req.rd_en) nt_q_ff <= nt_mem[req.nt_raddr];
   end

   // read of an entry written at the same edge returns the new byte
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         pat_fwd_ff  <= pat_we && (pat_waddr == req.pat_raddr);
         nt_fwd_ff   <= nt_we && (nt_waddr == req.nt_raddr);
         fwd_data_ff <= wdata;
      end
   end

   assign pat_rdata = pat_fwd_ff ? fwd_data_ff : pat_q_ff;
   assign nt_rdata  = nt_fwd_ff ? fwd_data_ff : nt_q_ff;
   assign fill_done = clr_done_ff;

endmodule

// ===== rtl/tile_background_ppu.sv =====
// top level of the tile background video unit: register file, raster and background pipe
// depends on tbppu_pkg and tbppu_vram
//
// Background-only picture unit. Each transaction on the req_ channel is a cpu
// register write, a register read or one dot tick of the 341x262 raster, and
// gives exactly one transaction on the rsp_ channel. The unit sustains one
// transaction per clock while rsp_ready holds: a transaction reads pattern or
// nametable memory in the cycle it is taken, and is finished in the second
// stage, where it can wait on rsp_ready, when the state is updated and the
// result goes into the output register. The next transaction's memory address
// is formed from the state being written back at that same edge, and a read
// that meets a write to the same byte is forwarded. After reset a fill sweep
// writes 128 to every byte of pattern and nametable memory, one address a
// clock (the nametable is swept alongside); no transaction is taken until it
// is over, while the mirroring register stays writable. Palette memory (32
// bytes) is held in flops and cleared by reset.
module tile_background_ppu (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_pixel_valid,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [5:0]  rsp_color_index,
   output logic        rsp_nmi,
   output logic        rsp_frame_done,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration register
   logic mirror_ff;

   // architectural state
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic        vbl_ff, vbl_in;
   logic [15:0] v_ff, v_in;
   logic [14:0] t_ff, t_in;
   logic [2:0]  fx_ff, fx_in;
   logic        tog_ff, tog_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic [8:0]  row_ff, row_in;
   logic [8:0]  dot_ff, dot_in;
   logic [7:0]  nti_ff, nti_in;
   logic [1:0]  nat_ff, nat_in;
   logic [7:0]  npl_ff, npl_in;
   logic [7:0]  nph_ff, nph_in;
   logic [15:0] psl_ff, psl_in;
   logic [15:0] psh_ff, psh_in;
   logic [15:0] asl_ff, asl_in;
   logic [15:0] ash_ff, ash_in;
   logic [7:0]  pal_ff [32];

   // second stage: transaction whose memory read is under way
   logic        s2_valid_ff, s2_valid_in;
   logic [1:0]  s2_cmd_ff;
   logic [2:0]  s2_idx_ff;
   logic [7:0]  s2_wdata_ff;
   logic        s2_fire, req_fire;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  o_read_data, rsp_read_data_ff;
   logic        o_pixel_valid, rsp_pixel_valid_ff;
   logic [7:0]  o_pixel_x, rsp_pixel_x_ff;
   logic [7:0]  o_pixel_y, rsp_pixel_y_ff;
   logic [5:0]  o_color, rsp_color_ff;
   logic        o_nmi, rsp_nmi_ff;
   logic        o_frame_done, rsp_frame_done_ff;

   // memory side
   tbppu_pkg::vram_req_type vreq;
   logic [7:0]  pat_rdata, nt_rdata;
   logic        fill_done;
   logic [13:0] rd_addr;

   // stage two working values
   logic [8:0]  t_dot, t_dm1, t_next;
   logic [4:0]  cy;
   logic        rendering;
   logic [7:0]  gmask;
   logic [7:0]  port_rdata;
   logic [7:0]  tick_rdata;
   logic [4:0]  pal_ridx;
   logic [1:0]  pix_sel, pal_sel;
   logic [3:0]  bit_sel;
   logic        pal_we;
   logic [4:0]  pal_widx;
   logic [15:0] addr_inc;

   assign s2_fire   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = fill_done && (!s2_valid_ff || s2_fire);
   assign req_fire  = req_valid && req_ready;

   // ---------------------------------------------------------------- stage two
   always_comb begin
      ctrl_in = ctrl_ff;  mask_in = mask_ff;  vbl_in = vbl_ff;
      v_in = v_ff;  t_in = t_ff;  fx_in = fx_ff;  tog_in = tog_ff;
      rbuf_in = rbuf_ff;  row_in = row_ff;  dot_in = dot_ff;
      nti_in = nti_ff;  nat_in = nat_ff;  npl_in = npl_ff;  nph_in = nph_ff;
      psl_in = psl_ff;  psh_in = psh_ff;  asl_in = asl_ff;  ash_in = ash_ff;

      o_read_data = '0;  o_pixel_valid = 1'b0;  o_pixel_x = '0;  o_pixel_y = '0;
      o_color = '0;  o_nmi = 1'b0;  o_frame_done = 1'b0;

      vreq.pat_we    = 1'b0;
      vreq.nt_we     = 1'b0;
      vreq.pat_waddr = v_ff[12:0];
      vreq.nt_waddr  = tbppu_pkg::nt_index(v_ff[11:0], mirror_ff);
      vreq.wdata     = s2_wdata_ff;
      pal_we         = 1'b0;
      pal_widx       = tbppu_pkg::pal_index(v_ff[4:0]);

      rendering = mask_ff[4] | mask_ff[3];
      gmask     = mask_ff[0] ? 8'h30 : 8'h3F;
      addr_inc  = ctrl_ff[2] ? 16'd32 : 16'd1;
      t_dot     = tbppu_pkg::eff_dot(row_ff, dot_ff);
      t_dm1     = t_dot - 9'd1;
      t_next    = t_dot + 9'd1;
      cy        = '0;
      pix_sel   = '0;
      pal_sel   = '0;
      bit_sel   = 4'd15 - {1'b0, fx_ff};

      // byte at the data port address
      if (!v_ff[13])                  port_rdata = pat_rdata;
      else if (v_ff[13:8] != 6'h3F)   port_rdata = nt_rdata;
      else port_rdata = pal_ff[tbppu_pkg::pal_index(v_ff[4:0])] & gmask;

      // tick fetches of the pattern phases use pattern memory, the rest nametable
      tick_rdata = ((t_dot != 9'd338) && (t_dot != 9'd340) && t_dm1[2]
                    && !t_dm1[0]) ? pat_rdata : nt_rdata;
      pal_ridx   = '0;

      if (s2_fire) begin
         case (s2_cmd_ff)
            tbppu_pkg::CMD_WRITE: begin
               case (s2_idx_ff)
                  tbppu_pkg::REG_CTRL: begin
                     ctrl_in       = s2_wdata_ff;
                     t_in[11:10]   = s2_wdata_ff[1:0];
                  end
                  tbppu_pkg::REG_MASK: mask_in = s2_wdata_ff;
                  tbppu_pkg::REG_SCROLL: begin
                     if (!tog_ff) begin
                        fx_in     = s2_wdata_ff[2:0];
                        t_in[4:0] = s2_wdata_ff[7:3];
                        tog_in    = 1'b1;
                     end else begin
                        t_in[14:12] = s2_wdata_ff[2:0];
                        t_in[9:5]   = s2_wdata_ff[7:3];
                        tog_in      = 1'b0;
                     end
                  end
                  tbppu_pkg::REG_ADDR: begin
                     if (!tog_ff) begin
                        t_in[14:8] = {1'b0, s2_wdata_ff[5:0]};
                        tog_in     = 1'b1;
                     end else begin
                        t_in[7:0] = s2_wdata_ff;
                        v_in      = {1'b0, t_ff[14:8], s2_wdata_ff};
                        tog_in    = 1'b0;
                     end
                  end
                  tbppu_pkg::REG_DATA: begin
                     if (!v_ff[13])                vreq.pat_we = 1'b1;
                     else if (v_ff[13:8] != 6'h3F) vreq.nt_we  = 1'b1;
                     else                          pal_we      = 1'b1;
                     v_in = v_ff + addr_inc;
                  end
                  default: ;
               endcase
            end

            tbppu_pkg::CMD_READ: begin
               case (s2_idx_ff)
                  tbppu_pkg::REG_STATUS: begin
                     o_read_data = {vbl_ff, 2'b00, rbuf_ff[4:0]};
                     vbl_in      = 1'b0;
                     tog_in      = 1'b0;
                  end
                  tbppu_pkg::REG_DATA: begin
                     rbuf_in     = port_rdata;
                     o_read_data = (v_ff[13:8] == 6'h3F) ? port_rdata : rbuf_ff;
                     v_in        = v_ff + addr_inc;
                  end
                  default: ;
               endcase
            end

            tbppu_pkg::CMD_TICK: begin
               if ((row_ff < tbppu_pkg::VIS_ROWS) || (row_ff == tbppu_pkg::PRE_ROW)) begin
                  if ((row_ff == tbppu_pkg::PRE_ROW) && (t_dot == 9'd1)) vbl_in = 1'b0;
                  if (((t_dot >= 9'd2) && (t_dot < 9'd258))
                      || ((t_dot >= 9'd321) && (t_dot < 9'd338))) begin
                     if (mask_ff[3]) begin
                        psl_in = {psl_in[14:0], 1'b0};
                        psh_in = {psh_in[14:0], 1'b0};
                        asl_in = {asl_in[14:0], 1'b0};
                        ash_in = {ash_in[14:0], 1'b0};
                     end
                     case (t_dm1[2:0])
                        3'd0: begin
                           psl_in = {psl_in[15:8], npl_ff};
                           psh_in = {psh_in[15:8], nph_ff};
                           asl_in = {asl_in[15:8], {8{nat_ff[0]}}};
                           ash_in = {ash_in[15:8], {8{nat_ff[1]}}};
                           nti_in = tick_rdata;
                        end
                        3'd2: begin
                           case ({v_ff[6], v_ff[1]})
                              2'b00:   nat_in = tick_rdata[1:0];
                              2'b01:   nat_in = tick_rdata[3:2];
                              2'b10:   nat_in = tick_rdata[5:4];
                              default: nat_in = tick_rdata[7:6];
                           endcase
                        end
                        3'd4: npl_in = tick_rdata;
                        3'd6: nph_in = tick_rdata;
                        3'd7: begin
                           if (rendering) begin
                              if (v_in[4:0] == 5'd31) begin
                                 v_in = {v_in[15:11], ~v_in[10], v_in[9:5], 5'd0};
                              end else begin
                                 v_in = v_in + 16'd1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
                  // vertical scroll step at the end of the visible part
                  if ((t_dot == 9'd256) && rendering) begin
                     if (v_in[14:12] != 3'd7) begin
                        v_in = v_in + 16'h1000;
                     end else begin
                        v_in[14:12] = 3'd0;
                        cy = v_in[9:5];
                        if (cy == 5'd29) begin
                           cy = 5'd0;
                           v_in[11] = ~v_in[11];
                        end else if (cy == 5'd31) begin
                           cy = 5'd0;
                        end else begin
                           cy = cy + 5'd1;
                        end
                        v_in[9:5] = cy;
                     end
                  end
                  if (t_dot == 9'd257) begin
                     psl_in = {psl_in[15:8], npl_in};
                     psh_in = {psh_in[15:8], nph_in};
                     asl_in = {asl_in[15:8], {8{nat_in[0]}}};
                     ash_in = {ash_in[15:8], {8{nat_in[1]}}};
                     if (rendering) begin
                        v_in[10]  = t_ff[10];
                        v_in[4:0] = t_ff[4:0];
                     end
                  end
                  if ((t_dot == 9'd338) || (t_dot == 9'd340)) nti_in = tick_rdata;
                  if ((row_ff == tbppu_pkg::PRE_ROW) && (t_dot >= 9'd280)
                      && (t_dot < 9'd305) && rendering) begin
                     v_in[14:11] = t_ff[14:11];
                     v_in[9:5]   = t_ff[9:5];
                  end
               end

               if ((row_ff == tbppu_pkg::VBL_ROW) && (t_dot == 9'd1)) begin
                  vbl_in = 1'b1;
                  o_nmi  = ctrl_ff[7];
               end

               if ((t_dot >= 9'd1) && (t_dot < 9'd257) && (row_ff < tbppu_pkg::VIS_ROWS)) begin
                  if (mask_ff[3]) begin
                     pix_sel = {psh_in[bit_sel], psl_in[bit_sel]};
                     pal_sel = {ash_in[bit_sel], asl_in[bit_sel]};
                  end
                  pal_ridx      = {1'b0, pal_sel, pix_sel};
                  o_pixel_valid = 1'b1;
                  o_pixel_x     = t_dm1[7:0];
                  o_pixel_y     = row_ff[7:0];
                  o_color       = 6'(pal_ff[pal_ridx] & gmask);
               end

               // raster advance
               if (t_next > tbppu_pkg::LAST_DOT) begin
                  dot_in = 9'd0;
                  if (row_ff == tbppu_pkg::PRE_ROW) begin
                     row_in = 9'd0;
                  end else begin
                     row_in = row_ff + 9'd1;
                     if (row_in >= tbppu_pkg::PRE_ROW) begin
                        row_in       = tbppu_pkg::PRE_ROW;
                        o_frame_done = 1'b1;
                     end
                  end
               end else begin
                  dot_in = t_next;
               end
            end

            default: ;
         endcase
      end

      // ------------------------------------------------------------- stage one
      // address formed from the state as it stands after this edge's update
      rd_addr        = tbppu_pkg::fetch_addr(req_command, row_in, dot_in, v_in,
                                             ctrl_in[4], nti_in);
      vreq.rd_en     = req_fire;
      vreq.pat_raddr = rd_addr[12:0];
      vreq.nt_raddr  = tbppu_pkg::nt_index(rd_addr[11:0], mirror_ff);
   end

   tbppu_vram u_vram (
      .clock     (clock),
      .reset     (reset),
      .req       (vreq),
      .pat_rdata (pat_rdata),
      .nt_rdata  (nt_rdata),
      .fill_done (fill_done)
   );

   // ---------------------------------------------------------------- registers
   assign s2_valid_in  = req_fire ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_ff);
   assign rsp_valid_in = s2_fire ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;  mask_ff <= '0;  vbl_ff <= 1'b0;
         v_ff <= '0;  t_ff <= '0;  fx_ff <= '0;  tog_ff <= 1'b0;
         rbuf_ff <= '0;  row_ff <= '0;  dot_ff <= '0;
         nti_ff <= '0;  nat_ff <= '0;  npl_ff <= '0;  nph_ff <= '0;
         psl_ff <= '0;  psh_ff <= '0;  asl_ff <= '0;  ash_ff <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;  mask_ff <= mask_in;  vbl_ff <= vbl_in;
         v_ff <= v_in;  t_ff <= t_in;  fx_ff <= fx_in;  tog_ff <= tog_in;
         rbuf_ff <= rbuf_in;  row_ff <= row_in;  dot_ff <= dot_in;
         nti_ff <= nti_in;  nat_ff <= nat_in;  npl_ff <= npl_in;  nph_ff <= nph_in;
         psl_ff <= psl_in;  psh_ff <= psh_in;  asl_ff <= asl_in;  ash_ff <= ash_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // palette bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) pal_ff[i] <= '0;
      end else if (pal_we) begin
         pal_ff[pal_widx] <= s2_wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_cmd_ff   <= req_command;
         s2_idx_ff   <= req_reg_index;
         s2_wdata_ff <= req_write_data;
      end
      if (s2_fire) begin
         rsp_read_data_ff   <= o_read_data;
         rsp_pixel_valid_ff <= o_pixel_valid;
         rsp_pixel_x_ff     <= o_pixel_x;
         rsp_pixel_y_ff     <= o_pixel_y;
         rsp_color_ff       <= o_color;
         rsp_nmi_ff         <= o_nmi;
         rsp_frame_done_ff  <= o_frame_done;
      end
   end

   // mirroring register on the apb port
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b0;
      end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
         mirror_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr == 3'd0) ? {31'd0, mirror_ff} : 32'd0;
   assign pready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_pixel_valid = rsp_pixel_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_color_index = rsp_color_ff;
   assign rsp_nmi         = rsp_nmi_ff;
   assign rsp_frame_done  = rsp_frame_done_ff;

`ifndef ASSERT_OFF
   // nothing enters the pipe before the fill sweep is over
   a_no_take_in_fill: assert property (@(posedge clock) disable iff (reset)
      !fill_done |-> !req_ready)
      else $error("transaction taken during memory fill");

   // raster dot counter stays inside a line
   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      dot_ff <= tbppu_pkg::LAST_DOT)
      else $error("raster dot out of range");

   // a drawn dot lies in the visible area and never on a frame wrap
   a_pixel_area: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixel_valid) |-> ((rsp_pixel_y < 8'd240) && !rsp_frame_done))
      else $error("dot outside visible area");

   // a finished transaction always lands in the output register
   a_s2_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> rsp_valid)
      else $error("result lost from output register");
`endif

endmodule

// ===== bench/tile_background_ppu_tb.sv =====
// self-checking testbench of the tile background video unit (tile_background_ppu)
// depends on tbppu_pkg and the rtl of the unit; carries its own model of the unit
// register accesses, whole raster lines of ticks and random traffic under idling
module tile_background_ppu_tb;

   // codes the package leaves unnamed
   localparam logic [1:0] CMD_NONE    = 2'd3;
   localparam logic [2:0] REG_SPARE3  = 3'd3;
   localparam logic [2:0] REG_SPARE4  = 3'd4;
   localparam logic [2:0] CSR_MIRROR  = 3'd0;
   localparam int         DOTS_LINE   = 341;

   typedef struct packed {
      logic [7:0] read_data;
      logic       pixel_valid;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [5:0] color_index;
      logic       nmi;
      logic       frame_done;
   } ppu_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [2:0]  req_reg_index;
   logic [7:0]  req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_data;
   logic        rsp_pixel_valid;
   logic [7:0]  rsp_pixel_x;
   logic [7:0]  rsp_pixel_y;
   logic [5:0]  rsp_color_index;
   logic        rsp_nmi;
   logic        rsp_frame_done;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tile_background_ppu uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_reg_index(req_reg_index), .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data),
      .rsp_pixel_valid(rsp_pixel_valid), .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y), .rsp_color_index(rsp_color_index),
      .rsp_nmi(rsp_nmi), .rsp_frame_done(rsp_frame_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock, period 20
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall time limit, well above the slowest correct run
   initial begin
      #(20 * 4_000_000);
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // shadow copy of the unit's state, advanced once per accepted transaction
   // ---------------------------------------------------------------
   logic        sh_mirror;
   logic [7:0]  sh_nt  [0:2047];
   logic [7:0]  sh_pat [0:8191];
   logic [7:0]  sh_pal [0:31];
   logic [7:0]  sh_ctrl, sh_mask, sh_status, sh_rbuf;
   logic [15:0] sh_v, sh_t;
   logic [2:0]  sh_fine_x;
   logic        sh_toggle;
   int unsigned sh_row, sh_dot;
   logic [7:0]  sh_tile, sh_attr, sh_plo, sh_phi;
   logic [15:0] sh_shift_plo, sh_shift_phi, sh_shift_alo, sh_shift_ahi;

   ppu_result_type pending_results[$];

   int errors;
   int pixels_seen, reads_seen;

   // test-controlled idling knobs
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int hold_left;

   task automatic shadow_reset();
      sh_mirror = 1'b0;
      for (int i = 0; i < 2048; i++) sh_nt[i] = 8'd128;
      for (int i = 0; i < 8192; i++) sh_pat[i] = 8'd128;
      for (int i = 0; i < 32; i++) sh_pal[i] = 8'd0;
      sh_ctrl = 0; sh_mask = 0; sh_status = 0; sh_rbuf = 0;
      sh_v = 0; sh_t = 0; sh_fine_x = 0; sh_toggle = 0;
      sh_row = 0; sh_dot = 0;
      sh_tile = 0; sh_attr = 0; sh_plo = 0; sh_phi = 0;
      sh_shift_plo = 0; sh_shift_phi = 0; sh_shift_alo = 0; sh_shift_ahi = 0;
   endtask

   function automatic int nt_slot(logic [11:0] a);
      logic bank;
      bank = sh_mirror ? a[11] : a[10];
      return {bank, a[9:0]};
   endfunction

   // backdrop entries of the upper half fold onto the lower half
   function automatic int pal_slot(logic [13:0] a);
      logic [4:0] e;
      e = a[4:0];
      if (e[4] && e[1:0] == 2'b00) e[4] = 1'b0;
      return e;
   endfunction

   function automatic logic [7:0] vram_fetch(logic [15:0] addr);
      logic [13:0] a;
      a = addr[13:0];
      if (a < 14'h2000) return sh_pat[a[12:0]];
      if (a < 14'h3F00) return sh_nt[nt_slot(a[11:0])];
      return sh_pal[pal_slot(a)] & (sh_mask[0] ? 8'h30 : 8'h3F);
   endfunction

   task automatic vram_store(logic [15:0] addr, logic [7:0] d);
      logic [13:0] a;
      a = addr[13:0];
      if (a < 14'h2000) sh_pat[a[12:0]] = d;
      else if (a < 14'h3F00) sh_nt[nt_slot(a[11:0])] = d;
      else sh_pal[pal_slot(a)] = d;
   endtask

   function automatic logic drawing();
      return (sh_mask & 8'h18) != 0;
   endfunction

   task automatic scroll_step_x();
      if (!drawing()) return;
      if (sh_v[4:0] == 5'd31) sh_v = (sh_v & ~16'h001F) ^ 16'h0400;
      else sh_v = sh_v + 16'd1;
   endtask

   task automatic scroll_step_y();
      logic [4:0] cy;
      if (!drawing()) return;
      if (sh_v[14:12] != 3'd7) begin
         sh_v = sh_v + 16'h1000;
         return;
      end
      sh_v = sh_v & ~16'h7000;
      cy = sh_v[9:5];
      if (cy == 5'd29) begin
         cy = 0;
         sh_v = sh_v ^ 16'h0800;
      end else if (cy == 5'd31) begin
         cy = 0;
      end else begin
         cy = cy + 5'd1;
      end
      sh_v[9:5] = cy;
   endtask

   task automatic reload_shifters();
      sh_shift_plo[7:0] = sh_plo;
      sh_shift_phi[7:0] = sh_phi;
      sh_shift_alo[7:0] = sh_attr[0] ? 8'hFF : 8'h00;
      sh_shift_ahi[7:0] = sh_attr[1] ? 8'hFF : 8'h00;
   endtask

   task automatic fetch_phase(int unsigned phase);
      logic [15:0] base;
      logic [7:0]  a;
      base = ({15'd0, sh_ctrl[4]} << 12) + ({8'd0, sh_tile} << 4) + {13'd0, sh_v[14:12]};
      case (phase)
         0: begin
            reload_shifters();
            sh_tile = vram_fetch(16'h2000 | (sh_v & 16'h0FFF));
         end
         2: begin
            a = vram_fetch(16'h23C0 | (sh_v & 16'h0C00) | ((sh_v >> 4) & 16'h38)
                           | ((sh_v >> 2) & 16'h07));
            if (sh_v[6]) a = a >> 4;
            if (sh_v[1]) a = a >> 2;
            sh_attr = a & 8'd3;
         end
         4: sh_plo = vram_fetch(base);
         6: sh_phi = vram_fetch(base + 16'd8);
         7: scroll_step_x();
         default: ;
      endcase
   endtask

   task automatic dot_tick(inout ppu_result_type r);
      int unsigned row, dot;
      logic [15:0] sel;
      logic [1:0]  pix, pal;
      if (sh_row == 0 && sh_dot == 0) sh_dot = 1;
      row = sh_row;
      dot = sh_dot;
      if (row < 240 || row == 261) begin
         if (row == 261 && dot == 1) sh_status[7] = 1'b0;
         if ((dot >= 2 && dot < 258) || (dot >= 321 && dot < 338)) begin
            if (sh_mask[3]) begin
               sh_shift_plo = sh_shift_plo << 1;
               sh_shift_phi = sh_shift_phi << 1;
               sh_shift_alo = sh_shift_alo << 1;
               sh_shift_ahi = sh_shift_ahi << 1;
            end
            fetch_phase((dot - 1) & 7);
         end
         if (dot == 256) scroll_step_y();
         if (dot == 257) begin
            reload_shifters();
            if (drawing()) sh_v = (sh_v & ~16'h041F) | (sh_t & 16'h041F);
         end
         if (dot == 338 || dot == 340) sh_tile = vram_fetch(16'h2000 | (sh_v & 16'h0FFF));
         if (row == 261 && dot >= 280 && dot < 305 && drawing())
            sh_v = (sh_v & ~16'h7BE0) | (sh_t & 16'h7BE0);
      end
      if (row == 241 && dot == 1) begin
         sh_status[7] = 1'b1;
         if (sh_ctrl[7]) r.nmi = 1'b1;
      end
      if (dot >= 1 && dot < 257 && row < 240) begin
         pix = 0;
         pal = 0;
         if (sh_mask[3]) begin
            sel = 16'h8000 >> sh_fine_x;
            pix = {|(sh_shift_phi & sel), |(sh_shift_plo & sel)};
            pal = {|(sh_shift_ahi & sel), |(sh_shift_alo & sel)};
         end
         r.pixel_valid = 1'b1;
         r.pixel_x = 8'(dot - 1);
         r.pixel_y = 8'(row);
         r.color_index = 6'(vram_fetch(16'h3F00 + {12'd0, pal, pix}) & 8'h3F);
      end
      dot++;
      if (dot >= 341) begin
         dot = 0;
         if (row == 261) row = 0;
         else begin
            row++;
            if (row >= 261) begin
               row = 261;
               r.frame_done = 1'b1;
            end
         end
      end
      sh_dot = dot;
      sh_row = row;
   endtask

   task automatic cpu_write(logic [2:0] idx, logic [7:0] d);
      case (idx)
         tbppu_pkg::REG_CTRL: begin
            sh_ctrl = d;
            sh_t[11:10] = d[1:0];
         end
         tbppu_pkg::REG_MASK: sh_mask = d;
         tbppu_pkg::REG_SCROLL: begin
            if (!sh_toggle) begin
               sh_fine_x = d[2:0];
               sh_t[4:0] = d[7:3];
            end else begin
               sh_t[14:12] = d[2:0];
               sh_t[9:5] = d[7:3];
            end
            sh_toggle = ~sh_toggle;
         end
         tbppu_pkg::REG_ADDR: begin
            if (!sh_toggle) begin
               sh_t = {2'b00, d[5:0], sh_t[7:0]};
            end else begin
               sh_t[7:0] = d;
               sh_v = sh_t;
            end
            sh_toggle = ~sh_toggle;
         end
         tbppu_pkg::REG_DATA: begin
            vram_store(sh_v, d);
            sh_v = sh_v + (sh_ctrl[2] ? 16'd32 : 16'd1);
         end
         default: ;
      endcase
   endtask

   task automatic cpu_read(logic [2:0] idx, output logic [7:0] d);
      d = 0;
      if (idx == tbppu_pkg::REG_STATUS) begin
         d = {sh_status[7:5], sh_rbuf[4:0]};
         sh_status[7] = 1'b0;
         sh_toggle = 1'b0;
      end else if (idx == tbppu_pkg::REG_DATA) begin
         d = sh_rbuf;
         sh_rbuf = vram_fetch(sh_v);
         if (sh_v[13:0] >= 14'h3F00) d = sh_rbuf;
         sh_v = sh_v + (sh_ctrl[2] ? 16'd32 : 16'd1);
      end
   endtask

   // works out the result of one transaction and queues it
   task automatic predict_result(logic [1:0] cmd, logic [2:0] idx, logic [7:0] d);
      ppu_result_type r;
      r = '0;
      case (cmd)
         tbppu_pkg::CMD_WRITE: cpu_write(idx, d);
         tbppu_pkg::CMD_READ:  cpu_read(idx, r.read_data);
         tbppu_pkg::CMD_TICK:  dot_tick(r);
         default: ;
      endcase
      pending_results.push_back(r);
   endtask

   // ---------------------------------------------------------------
   // result side: stalls and checking
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         // long hold-off so the pipe fills and stalls the request side
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      ppu_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                        rsp_read_data);
               errors++;
            end
            if (rsp_pixel_valid !== want.pixel_valid) begin
               $display("%0t: pixel_valid expected %b actual %b", $time, want.pixel_valid,
                        rsp_pixel_valid);
               errors++;
            end
            if (rsp_pixel_x !== want.pixel_x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x,
                        rsp_pixel_x);
               errors++;
            end
            if (rsp_pixel_y !== want.pixel_y) begin
               $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y,
                        rsp_pixel_y);
               errors++;
            end
            if (rsp_color_index !== want.color_index) begin
               $display("%0t: color_index expected %h actual %h", $time, want.color_index,
                        rsp_color_index);
               errors++;
            end
            if (rsp_nmi !== want.nmi) begin
               $display("%0t: nmi expected %b actual %b", $time, want.nmi, rsp_nmi);
               errors++;
            end
            if (rsp_frame_done !== want.frame_done) begin
               $display("%0t: frame_done expected %b actual %b", $time, want.frame_done,
                        rsp_frame_done);
               errors++;
            end
            pixels_seen += want.pixel_valid;
            if (want.read_data != 0) reads_seen++;
         end
      end
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   task automatic send_item(logic [1:0] cmd, logic [2:0] idx, logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_reg_index  <= idx;
      req_write_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_result(cmd, idx, d);
   endtask

   task automatic set_vram_addr(logic [13:0] a);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_ADDR, {2'b00, a[13:8]});
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_ADDR, a[7:0]);
   endtask

   // lets every queued result drain with the request side idle, then waits for the pipe
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $display("timeout waiting for %0d results", pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
      repeat (8) @(posedge clock);
   endtask

   // apb write of the mirroring register, only while idle
   task automatic write_mirroring(logic m);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_MIRROR;
      pwdata  <= {31'd0, m};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sh_mirror = m;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // unused registers, unknown command, status and data port with its buffer
   task automatic test_register_access();
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_STATUS, 8'h00);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_CTRL, 8'h00);
      send_item(tbppu_pkg::CMD_READ, REG_SPARE3, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, REG_SPARE4, 8'hFF);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_STATUS, 8'hFF);
      send_item(CMD_NONE, 3'd7, 8'hFF);
      // palette writes incl. the aliased backdrop entry, read back with greyscale
      set_vram_addr(14'h3F10);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'hFF);
      set_vram_addr(14'h3F00);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_DATA, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_MASK, 8'h01);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_DATA, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_MASK, 8'h00);
      // nametable read is buffered, increment by 32
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_CTRL, 8'h04);
      set_vram_addr(14'h2000);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_DATA, 8'h00);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_DATA, 8'h00);
      // top of the address space and the wrap past it
      set_vram_addr(14'h3FFF);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'h2A);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_STATUS, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_SCROLL, 8'hFF);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_SCROLL, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_CTRL, 8'h00);
   endtask

   // a scene in memory, then two raster lines of ticks with rendering on
   task automatic test_raster_lines();
      for (int i = 0; i < 16; i++) begin
         if (i == 0) set_vram_addr(14'h3F00);
         send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'(i * 5 + 1));
      end
      set_vram_addr(14'h0010);
      for (int i = 0; i < 16; i++)
         send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'($urandom));
      set_vram_addr(14'h2000);
      for (int i = 0; i < 8; i++)
         send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'h01);
      set_vram_addr(14'h23C0);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'hE4);
      send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_STATUS, 8'h00);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_SCROLL, 8'h0B);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_SCROLL, 8'h05);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_CTRL, 8'h90);
      send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_MASK, 8'h1E);
      for (int i = 0; i < 2 * DOTS_LINE + 20; i++) begin
         // status sampled now and then in the middle of a line
         if (i % 250 == 249) send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_STATUS, 8'h00);
         send_item(tbppu_pkg::CMD_TICK, 3'd0, 8'h00);
      end
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_item(tbppu_pkg::CMD_TICK, 3'($urandom), 8'($urandom));
      end else if (pick < 70) begin
         // well-formed data port sequence: address pair then a burst
         set_vram_addr(14'($urandom));
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1))
               send_item(tbppu_pkg::CMD_WRITE, tbppu_pkg::REG_DATA, 8'($urandom));
            else
               send_item(tbppu_pkg::CMD_READ, tbppu_pkg::REG_DATA, 8'($urandom));
         end
      end else if (pick < 85) begin
         send_item(tbppu_pkg::CMD_WRITE, 3'($urandom), 8'($urandom));
      end else if (pick < 97) begin
         send_item(tbppu_pkg::CMD_READ, 3'($urandom), 8'($urandom));
      end else begin
         send_item(CMD_NONE, 3'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_random_phase(int idle, int stall, int count, logic mirror, int hold);
      write_mirroring(mirror);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      hold_request   = hold;
      for (int i = 0; i < count; i++) random_item();
      drain();
   endtask

   initial begin
      errors = 0;
      pixels_seen = 0; reads_seen = 0;
      send_idle_pct = 0; recv_stall_pct = 0; hold_request = 0; hold_left = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_command = tbppu_pkg::CMD_TICK; req_reg_index = 0;
      req_write_data = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      shadow_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // register writable during the fill sweep
      write_mirroring(1'b1);
      write_mirroring(1'b0);

      test_register_access();
      drain();
      test_raster_lines();
      drain();
      // sender keeps offering while results are held back
      test_random_phase(0, 0, 100, 1'b1, 400);
      test_random_phase(76, 0, 90, 1'b0, 0);
      test_random_phase(0, 76, 90, 1'b1, 0);
      test_random_phase(27, 27, 100, 1'b0, 0);
      test_random_phase(0, 0, 70, 1'b1, 0);

      $display("covered register and data port accesses, palette folding, %0d drawn dots,",
               pixels_seen);
      $display("%0d non-zero reads, both mirrorings, idling and a long result hold-off",
               reads_seen);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
